// File: hw/rtl/msdw_pkg.sv
`timescale 1ns / 1ps
package msdw_pkg;

    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_UNREGISTER = 3'd1;
    localparam logic [2:0] OP_TICK       = 3'd2;
    localparam logic [2:0] OP_STOP_RECV  = 3'd3;
    localparam logic [2:0] OP_SET_LIFE   = 3'd4;
    localparam logic [2:0] OP_SCAN       = 3'd5;

    localparam logic [1:0] CAUSE_NONE     = 2'd0;
    localparam logic [1:0] CAUSE_DEADLINE = 2'd1;
    localparam logic [1:0] CAUSE_RECV     = 2'd2;

    localparam logic [4:0]  MAX_OUT    = 5'd16;
    localparam logic [15:0] TIMEOUT_RST = 16'd10;
    localparam logic [15:0] CNT_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [21:0] owner_id;
        logic [15:0] deadline_ticks;
        logic        watched;
        logic [15:0] life_value;
    } in_beat_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  slot_index;
        logic [21:0] expired_id;
        logic [1:0]  cause;
        logic [15:0] old_lifetime;
        logic [4:0]  free_slots;
        logic        last;
    } out_beat_t;

    typedef struct packed {
        logic [21:0] owner;
        logic [15:0] lifetime;
        logic [15:0] deadline;
        logic [15:0] recv_delay;
        logic        recv_stopped;
        logic        watched;
    } slot_rec_t;

    typedef struct packed {
        logic capture;
        logic walk_start;
        logic emit_phase;
        logic reg_do;
        logic resp;
        logic fin_free;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic any_expired;
    } dp_stat_t;

endpackage

// File: hw/rtl/msdw_ram.sv
`timescale 1ns / 1ps
module msdw_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/msdw_ctrl.sv
`timescale 1ns / 1ps
module msdw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         opcode,
    input  msdw_pkg::dp_stat_t stat,
    output msdw_pkg::dp_cmd_t  cmd,
    output logic               busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG,
        S_WALK,
        S_CHK,
        S_EMIT,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   scan_reg;
    logic   scan_next;

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    scan_next   = (opcode == msdw_pkg::OP_SCAN);
                    case (opcode)
                        msdw_pkg::OP_REGISTER:
                        begin
                            state_next = S_REG;
                        end
                        msdw_pkg::OP_UNREGISTER, msdw_pkg::OP_TICK, msdw_pkg::OP_STOP_RECV,
                        msdw_pkg::OP_SET_LIFE, msdw_pkg::OP_SCAN:
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_REG:
            begin
                cmd.reg_do = 1'b1;
                state_next = S_RESP;
            end
            S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.fin_free = 1'b1;
                if (scan_reg && stat.any_expired)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.emit_phase = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_EMIT:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                cmd.resp   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            scan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !busy)
        else $error("capture while busy");
    a_emit_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ($past(state_reg) == S_EMIT || $past(state_reg) == S_CHK))
        else $error("emit pass entered out of order");
    a_resp_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp |=> !busy)
        else $error("single response did not end the operation");

endmodule

// File: hw/rtl/msdw_dp.sv
`timescale 1ns / 1ps
module msdw_dp #(
    parameter int SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  msdw_pkg::in_beat_t  req,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  msdw_pkg::dp_cmd_t   cmd,
    output msdw_pkg::dp_stat_t  stat,
    output logic                result_valid,
    output msdw_pkg::out_beat_t result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RW = $bits(msdw_pkg::slot_rec_t);

    msdw_pkg::in_beat_t  op_reg;
    logic [15:0]         timeout_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic [SLOTS-1:0]    valid_next;
    logic [CW-1:0]       free_cnt_reg;
    logic [CW-1:0]       free_cnt_next;
    logic                rd_on_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic                ex_vld_reg;
    logic [IW-1:0]       ex_idx_reg;
    logic                phase2_reg;
    logic [4:0]          exp_cnt_reg;
    logic [4:0]          exp_cnt_next;
    logic [4:0]          emit_cnt_reg;
    logic [4:0]          emit_cnt_next;
    logic [4:0]          fin_free_reg;
    logic                found_reg;
    logic                found_next;
    logic                res_status_reg;
    logic                res_status_next;
    logic [3:0]          res_idx_reg;
    logic [3:0]          res_idx_next;
    logic [15:0]         res_life_reg;
    logic [15:0]         res_life_next;
    logic                out_vld_reg;
    logic                out_vld_next;
    msdw_pkg::out_beat_t out_reg;
    msdw_pkg::out_beat_t out_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    msdw_pkg::slot_rec_t ram_wdata;
    msdw_pkg::slot_rec_t rec;
    logic [RW-1:0]       ram_rdata;

    logic                free_any;
    logic [IW-1:0]       free_idx;
    logic                ex_occ;
    logic                is_lookup;
    logic [1:0]          ex_cause;
    logic [7:0]          fin_sum;

    msdw_ram #(
        .WIDTH(RW),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_idx_reg),
        .rdata(ram_rdata)
    );

    assign rec = msdw_pkg::slot_rec_t'(ram_rdata);

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!valid_reg[i] && !free_any)
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign ex_occ    = ex_vld_reg && valid_reg[ex_idx_reg];
    assign is_lookup = (op_reg.opcode == msdw_pkg::OP_UNREGISTER)
                    || (op_reg.opcode == msdw_pkg::OP_STOP_RECV)
                    || (op_reg.opcode == msdw_pkg::OP_SET_LIFE);

    always_comb
    begin
        ex_cause = msdw_pkg::CAUSE_NONE;
        if (ex_occ && (rec.owner > 22'd1) && rec.watched)
        begin
            if (rec.deadline < rec.lifetime)
            begin
                ex_cause = msdw_pkg::CAUSE_DEADLINE;
            end
            else if (!rec.recv_stopped && (rec.recv_delay > timeout_reg))
            begin
                ex_cause = msdw_pkg::CAUSE_RECV;
            end
        end
    end

    assign fin_sum = 8'(free_cnt_reg) + 8'(exp_cnt_reg);

    always_comb
    begin
        valid_next      = valid_reg;
        free_cnt_next   = free_cnt_reg;
        exp_cnt_next    = exp_cnt_reg;
        emit_cnt_next   = emit_cnt_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_life_next   = res_life_reg;
        out_vld_next    = 1'b0;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = ex_idx_reg;
        ram_wdata       = rec;

        if (cmd.capture)
        begin
            exp_cnt_next    = '0;
            emit_cnt_next   = '0;
            found_next      = 1'b0;
            res_status_next = (req.opcode > msdw_pkg::OP_SCAN);
            res_idx_next    = '0;
            res_life_next   = '0;
        end

        if (cmd.reg_do)
        begin
            if ((op_reg.owner_id != '0) && free_any)
            begin
                ram_we                 = 1'b1;
                ram_waddr              = free_idx;
                ram_wdata.owner        = op_reg.owner_id;
                ram_wdata.lifetime     = '0;
                ram_wdata.deadline     = op_reg.deadline_ticks;
                ram_wdata.recv_delay   = '0;
                ram_wdata.recv_stopped = 1'b0;
                ram_wdata.watched      = op_reg.watched;
                valid_next[free_idx]   = 1'b1;
                free_cnt_next          = free_cnt_reg - CW'(1);
                res_idx_next           = 4'(free_idx);
            end
            else
            begin
                res_status_next = 1'b1;
            end
        end

        if (ex_occ && (op_reg.opcode == msdw_pkg::OP_TICK))
        begin
            ram_we = 1'b1;
            if (rec.lifetime != msdw_pkg::CNT_MAX)
            begin
                ram_wdata.lifetime = rec.lifetime + 16'd1;
            end
            if (!rec.recv_stopped && (rec.recv_delay != msdw_pkg::CNT_MAX))
            begin
                ram_wdata.recv_delay = rec.recv_delay + 16'd1;
            end
        end

        if (ex_occ && is_lookup && !found_reg && (rec.owner == op_reg.owner_id))
        begin
            found_next   = 1'b1;
            res_idx_next = 4'(ex_idx_reg);
            case (op_reg.opcode)
                msdw_pkg::OP_UNREGISTER:
                begin
                    res_life_next          = rec.lifetime;
                    valid_next[ex_idx_reg] = 1'b0;
                    free_cnt_next          = free_cnt_reg + CW'(1);
                end
                msdw_pkg::OP_STOP_RECV:
                begin
                    ram_we                 = 1'b1;
                    ram_wdata.recv_stopped = 1'b1;
                end
                msdw_pkg::OP_SET_LIFE:
                begin
                    ram_we             = 1'b1;
                    ram_wdata.lifetime = op_reg.life_value;
                end
                default:
                begin
                    found_next = found_reg;
                end
            endcase
        end

        if ((op_reg.opcode == msdw_pkg::OP_SCAN) && (ex_cause != msdw_pkg::CAUSE_NONE))
        begin
            if (!phase2_reg)
            begin
                if (exp_cnt_reg < msdw_pkg::MAX_OUT)
                begin
                    exp_cnt_next = exp_cnt_reg + 5'd1;
                end
            end
            else if (emit_cnt_reg < exp_cnt_reg)
            begin
                emit_cnt_next           = emit_cnt_reg + 5'd1;
                valid_next[ex_idx_reg]  = 1'b0;
                free_cnt_next           = free_cnt_reg + CW'(1);
                out_vld_next            = 1'b1;
                out_next.status         = 1'b0;
                out_next.slot_index     = 4'(ex_idx_reg);
                out_next.expired_id     = rec.owner;
                out_next.cause          = ex_cause;
                out_next.old_lifetime   = '0;
                out_next.free_slots     = fin_free_reg;
                out_next.last           = ((emit_cnt_reg + 5'd1) == exp_cnt_reg);
            end
        end

        if (cmd.resp)
        begin
            out_vld_next          = 1'b1;
            out_next.status       = res_status_reg || (is_lookup && !found_reg);
            out_next.slot_index   = res_idx_reg;
            out_next.expired_id   = '0;
            out_next.cause        = msdw_pkg::CAUSE_NONE;
            out_next.old_lifetime = res_life_reg;
            out_next.free_slots   = 5'(free_cnt_reg);
            out_next.last         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= msdw_pkg::TIMEOUT_RST;
            valid_reg      <= '0;
            free_cnt_reg   <= CW'(SLOTS);
            rd_on_reg      <= 1'b0;
            rd_idx_reg     <= '0;
            ex_vld_reg     <= 1'b0;
            ex_idx_reg     <= '0;
            phase2_reg     <= 1'b0;
            exp_cnt_reg    <= '0;
            emit_cnt_reg   <= '0;
            fin_free_reg   <= '0;
            found_reg      <= 1'b0;
            res_status_reg <= 1'b0;
            res_idx_reg    <= '0;
            res_life_reg   <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            valid_reg      <= valid_next;
            free_cnt_reg   <= free_cnt_next;
            exp_cnt_reg    <= exp_cnt_next;
            emit_cnt_reg   <= emit_cnt_next;
            found_reg      <= found_next;
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
            res_life_reg   <= res_life_next;
            out_vld_reg    <= out_vld_next;
            if (cmd.fin_free)
            begin
                fin_free_reg <= fin_sum[4:0];
            end
            ex_vld_reg <= rd_on_reg;
            ex_idx_reg <= rd_idx_reg;
            if (cmd.walk_start)
            begin
                rd_on_reg  <= 1'b1;
                rd_idx_reg <= '0;
                phase2_reg <= cmd.emit_phase;
            end
            else if (rd_on_reg)
            begin
                if (rd_idx_reg == IW'(SLOTS - 1))
                begin
                    rd_on_reg <= 1'b0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.capture)
        begin
            op_reg <= req;
        end
    end

    assign stat.walk_done   = ex_vld_reg && (ex_idx_reg == IW'(SLOTS - 1));
    assign stat.any_expired = (exp_cnt_reg != '0);
    assign result_valid     = out_vld_reg;
    assign result           = out_reg;

    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(valid_reg) + int'(free_cnt_reg)) == SLOTS)
        else $error("free count out of step with occupied slots");
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= exp_cnt_reg)
        else $error("more expirations emitted than counted");
    a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.last) |=> !out_vld_reg)
        else $error("result beat after last");

endmodule

// File: hw/rtl/multi_slot_deadline_watchdog.sv
`timescale 1ns / 1ps
// Table of SLOTS watchdog slots kept in one RAM and walked one slot per cycle.
// Register needs no table walk; unregister, tick, stop and set lifetime walk
// the whole table; a scan counts expirations in one walk and, when any slot
// expired, frees and reports them in a second walk. Each result beat is on
// result for exactly one cycle with result_valid high and cannot be held off;
// the beats of one scan come during the second walk, not always in adjacent
// cycles, and last marks the final one. start is taken only while busy is low.
module multi_slot_deadline_watchdog #(
    parameter int SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  msdw_pkg::in_beat_t  req,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    output logic                result_valid,
    output msdw_pkg::out_beat_t result
);

    msdw_pkg::dp_cmd_t  cmd;
    msdw_pkg::dp_stat_t stat;

    msdw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .opcode(req.opcode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    msdw_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

// File: dv/msdw_checker.sv
`timescale 1ns / 1ps
module msdw_checker
    import msdw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_beat_t  req,
    input  logic      cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic      result_valid,
    input  out_beat_t result,
    output int        fail_count,
    output int        pending_beats,
    output int        beats_seen,
    output int        expiries_seen
);
    localparam int NSLOT = 16;

    logic [21:0] m_owner [NSLOT];
    logic [15:0] m_life [NSLOT];
    logic [15:0] m_dl [NSLOT];
    logic [15:0] m_rd [NSLOT];
    logic        m_stop [NSLOT];
    logic        m_watch [NSLOT];
    logic [15:0] m_timeout;
    out_beat_t   expected_beats[$];

    assign pending_beats = expected_beats.size();

    function automatic out_beat_t mk(logic st, logic [3:0] sl, logic [21:0] id,
                                     logic [1:0] c, logic [15:0] ol);
        out_beat_t b;
        b = '0;
        b.status = st;
        b.slot_index = sl;
        b.expired_id = id;
        b.cause = c;
        b.old_lifetime = ol;
        return b;
    endfunction

    function automatic int lookup(logic [21:0] id);
        if (id == 0) return -1;
        for (int s = 0; s < NSLOT; s++)
            if (m_owner[s] == id) return s;
        return -1;
    endfunction

    function automatic void free_slot(int s);
        m_owner[s] = '0;
        m_life[s] = '0;
        m_dl[s] = '0;
        m_rd[s] = '0;
        m_stop[s] = 1'b1;
        m_watch[s] = 1'b0;
    endfunction

    task automatic predict_watchdog(in_beat_t r);
        out_beat_t outs[$];
        int i;
        int nfree;
        logic [1:0] c;
        i = -1;
        case (r.opcode)
            OP_REGISTER:
            begin
                if (r.owner_id != 0)
                    for (int s = 0; s < NSLOT; s++)
                        if (m_owner[s] == 0)
                        begin
                            i = s;
                            break;
                        end
                if (i < 0)
                    outs.push_back(mk(1'b1, 0, 0, CAUSE_NONE, 0));
                else
                begin
                    m_owner[i] = r.owner_id;
                    m_life[i] = '0;
                    m_stop[i] = 1'b0;
                    m_rd[i] = '0;
                    m_dl[i] = r.deadline_ticks;
                    m_watch[i] = r.watched;
                    outs.push_back(mk(1'b0, i[3:0], 0, CAUSE_NONE, 0));
                end
            end
            OP_UNREGISTER:
            begin
                i = lookup(r.owner_id);
                if (i < 0)
                    outs.push_back(mk(1'b1, 0, 0, CAUSE_NONE, 0));
                else
                begin
                    outs.push_back(mk(1'b0, i[3:0], 0, CAUSE_NONE, m_life[i]));
                    free_slot(i);
                end
            end
            OP_TICK:
            begin
                for (int s = 0; s < NSLOT; s++)
                    if (m_owner[s] != 0)
                    begin
                        if (m_life[s] != CNT_MAX) m_life[s]++;
                        if (!m_stop[s] && m_rd[s] != CNT_MAX) m_rd[s]++;
                    end
                outs.push_back(mk(1'b0, 0, 0, CAUSE_NONE, 0));
            end
            OP_STOP_RECV, OP_SET_LIFE:
            begin
                i = lookup(r.owner_id);
                if (i < 0)
                    outs.push_back(mk(1'b1, 0, 0, CAUSE_NONE, 0));
                else
                begin
                    if (r.opcode == OP_STOP_RECV) m_stop[i] = 1'b1;
                    else m_life[i] = r.life_value;
                    outs.push_back(mk(1'b0, i[3:0], 0, CAUSE_NONE, 0));
                end
            end
            OP_SCAN:
            begin
                for (int s = 0; s < NSLOT && outs.size() < MAX_OUT; s++)
                begin
                    c = CAUSE_NONE;
                    if (m_owner[s] > 1 && m_watch[s])
                    begin
                        if (m_dl[s] < m_life[s]) c = CAUSE_DEADLINE;
                        else if (!m_stop[s] && m_rd[s] > m_timeout) c = CAUSE_RECV;
                    end
                    if (c != CAUSE_NONE)
                    begin
                        outs.push_back(mk(1'b0, s[3:0], m_owner[s], c, 0));
                        free_slot(s);
                    end
                end
                if (outs.size() == 0)
                    outs.push_back(mk(1'b0, 0, 0, CAUSE_NONE, 0));
            end
            default:
                outs.push_back(mk(1'b1, 0, 0, CAUSE_NONE, 0));
        endcase
        nfree = 0;
        for (int s = 0; s < NSLOT; s++)
            if (m_owner[s] == 0) nfree++;
        foreach (outs[k])
        begin
            outs[k].free_slots = nfree[4:0];
            outs[k].last = (k == outs.size() - 1);
            expected_beats.push_back(outs[k]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSLOT; s++)
            begin
                m_owner[s] = '0;
                m_life[s] = '0;
                m_dl[s] = '0;
                m_rd[s] = '0;
                m_stop[s] = 1'b0;
                m_watch[s] = 1'b0;
            end
            m_timeout = TIMEOUT_RST;
            fail_count <= 0;
            beats_seen <= 0;
            expiries_seen <= 0;
            expected_beats.delete();
        end
        else
        begin
            if (result_valid)
            begin
                beats_seen <= beats_seen + 1;
                if (result.cause != CAUSE_NONE) expiries_seen <= expiries_seen + 1;
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %p", $time, result);
                    fail_count <= fail_count + 1;
                end
                else if (expected_beats[0] !== result)
                begin
                    $display("%0t: beat mismatch, expected %p, actual %p",
                             $time, expected_beats[0], result);
                    fail_count <= fail_count + 1;
                    void'(expected_beats.pop_front());
                end
                else
                    void'(expected_beats.pop_front());
            end
            if (cfg_we) m_timeout = cfg_wdata;
            if (start && !busy) predict_watchdog(req);
        end
    end
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import msdw_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_beat_t  req;
    logic      cfg_we;
    logic [15:0] cfg_wdata;
    logic      result_valid;
    out_beat_t result;
    int        fail_count;
    int        pending_beats;
    int        beats_seen;
    int        expiries_seen;
    int        cycle_count;
    int        items_sent;
    bit        no_gaps;

    localparam int CYCLE_LIMIT = 400000;

    multi_slot_deadline_watchdog u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result)
    );

    msdw_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending_beats(pending_beats),
        .beats_seen(beats_seen), .expiries_seen(expiries_seen)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_beat(logic [2:0] op, logic [21:0] id, logic [15:0] dl,
                             logic wt, logic [15:0] lv);
        in_beat_t b;
        int gap;
        gap = 1;
        if (!no_gaps && $urandom_range(0, 2) == 0)
        begin
            gap = 1 + $urandom_range(1, 15);
        end
        repeat (gap) @(posedge clk);
        b.opcode = op;
        b.owner_id = id;
        b.deadline_ticks = dl;
        b.watched = wt;
        b.life_value = lv;
        start <= 1'b1;
        req <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        items_sent++;
    endtask

    task automatic settle_and_config(logic [15:0] value);
        while (pending_beats != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        while (busy) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [21:0] pick_id();
        case ($urandom_range(0, 9))
            0: return 22'd1;
            1: return 22'h3FFFFF;
            2: return 22'd0;
            3: return 22'($urandom);
            default: return 22'($urandom_range(2, 9));
        endcase
    endfunction

    task automatic random_item();
        logic [2:0] op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) op = OP_REGISTER;
        else if (r < 35) op = OP_UNREGISTER;
        else if (r < 60) op = OP_TICK;
        else if (r < 68) op = OP_STOP_RECV;
        else if (r < 78) op = OP_SET_LIFE;
        else if (r < 97) op = OP_SCAN;
        else op = 3'($urandom_range(6, 7));
        send_beat(op, pick_id(),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                  ($urandom_range(0, 3) != 0),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)));
    endtask

    initial
    begin
        cycle_count = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: id extremes, full table, saturation, both causes
        send_beat(OP_REGISTER, 22'd0, 16'd5, 1'b1, 16'd0);
        send_beat(OP_UNREGISTER, 22'd0, 16'd0, 1'b0, 16'd0);
        send_beat(OP_STOP_RECV, 22'd7, 16'd0, 1'b0, 16'd0);
        send_beat(OP_SET_LIFE, 22'd0, 16'd0, 1'b0, 16'd3);
        send_beat(3'd6, 22'd5, 16'd0, 1'b0, 16'd0);
        send_beat(3'd7, 22'h3FFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
        send_beat(OP_SCAN, 22'd0, 16'd0, 1'b0, 16'd0);
        for (int k = 0; k < 16; k++)
            send_beat(OP_REGISTER, (k == 0) ? 22'd1 : (k == 15) ? 22'h3FFFFF : 22'(k + 1),
                      16'(k % 4), k[0] | (k < 4), 16'd0);
        send_beat(OP_REGISTER, 22'd99, 16'd0, 1'b1, 16'd0);
        send_beat(OP_SET_LIFE, 22'd3, 16'd0, 1'b0, 16'hFFFF);
        send_beat(OP_TICK, 22'd0, 16'd0, 1'b0, 16'd0);
        send_beat(OP_STOP_RECV, 22'd4, 16'd0, 1'b0, 16'd0);
        send_beat(OP_UNREGISTER, 22'd5, 16'd0, 1'b0, 16'd0);
        send_beat(OP_SCAN, 22'd0, 16'd0, 1'b0, 16'd0);

        settle_and_config(16'd0);
        send_beat(OP_REGISTER, 22'd12, 16'hFFFF, 1'b1, 16'd0);
        send_beat(OP_TICK, 22'd0, 16'd0, 1'b0, 16'd0);
        send_beat(OP_SCAN, 22'd0, 16'd0, 1'b0, 16'd0);
        for (int k = 0; k < 45; k++) random_item();

        settle_and_config(16'hFFFF);
        for (int k = 0; k < 40; k++) random_item();

        settle_and_config(16'($urandom_range(1, 4)));
        for (int k = 0; k < 40; k++) random_item();
        no_gaps = 1'b1;
        for (int k = 0; k < 30; k++) random_item();
        send_beat(OP_SCAN, 22'd0, 16'd0, 1'b0, 16'd0);

        while (pending_beats != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("%0d items sent, %0d result beats checked, %0d expirations seen",
                 items_sent, beats_seen, expiries_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/msdw_pkg.sv
hw/rtl/msdw_ram.sv
hw/rtl/msdw_ctrl.sv
hw/rtl/msdw_dp.sv
hw/rtl/multi_slot_deadline_watchdog.sv
dv/msdw_checker.sv
dv/tb_top.sv
